>>> src/srs_pkg.sv
package srs_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int SCORE_W    = 32;
  localparam int NAME_W     = 64;
  localparam int NAME_WORDS = 4;
  localparam int RANK_W     = 7;
  // top byte of the last name word is always stored as zero
  localparam int NAME_KEEP_W = 56;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [NAME_WORDS-1:0][NAME_W-1:0] name_blk_t;

  typedef struct packed {
    action_t                    action;
    logic signed [SCORE_W-1:0]  score;
    logic [NAME_W-1:0]          name_word0;
    logic [NAME_W-1:0]          name_word1;
    logic [NAME_W-1:0]          name_word2;
    logic [NAME_W-1:0]          name_word3;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic [RANK_W-1:0]          rank;
    logic signed [SCORE_W-1:0]  entry_score;
    logic [NAME_W-1:0]          entry_name0;
    logic [NAME_W-1:0]          entry_name1;
    logic [NAME_W-1:0]          entry_name2;
    logic [NAME_W-1:0]          entry_name3;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic entry_we;
    logic tag_we;
  } store_ctl_t;

  typedef struct packed {
    logic load;
    logic acc;
  } rank_ctl_t;

endpackage

>>> src/srs_store.sv
module srs_store #(
  parameter  int CAPACITY = srs_pkg::CAPACITY_DEF,
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                               clk,
  input  srs_pkg::store_ctl_t                ctl,
  input  logic [IDX_W-1:0]                   wr_addr,
  input  logic signed [srs_pkg::SCORE_W-1:0] wr_score,
  input  srs_pkg::name_blk_t                 wr_name,
  input  logic [IDX_W-1:0]                   tag_addr,
  input  logic [IDX_W-1:0]                   wr_tag,
  input  logic [IDX_W-1:0]                   rd_addr,
  output logic signed [srs_pkg::SCORE_W-1:0] rd_score,
  output srs_pkg::name_blk_t                 rd_name,
  output logic [IDX_W-1:0]                   rd_tag
);

  // entries live in fixed slots; the tag gives each slot its list position
  logic signed [srs_pkg::SCORE_W-1:0] score_mem [CAPACITY];
  srs_pkg::name_blk_t                 name_mem  [CAPACITY];
  logic [IDX_W-1:0]                   tag_mem   [CAPACITY];

  logic signed [srs_pkg::SCORE_W-1:0] rd_score_r;
  srs_pkg::name_blk_t                 rd_name_r;
  logic [IDX_W-1:0]                   rd_tag_r;

  always_ff @(posedge clk) begin
    if (ctl.entry_we) begin
      score_mem[wr_addr] <= wr_score;
      name_mem[wr_addr]  <= wr_name;
    end
    rd_score_r <= score_mem[rd_addr];
    rd_name_r  <= name_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[tag_addr] <= wr_tag;
    end
    rd_tag_r <= tag_mem[rd_addr];
  end

  assign rd_score = rd_score_r;
  assign rd_name  = rd_name_r;
  assign rd_tag   = rd_tag_r;

endmodule

>>> src/srs_rank.sv
module srs_rank #(
  parameter  int CAPACITY = srs_pkg::CAPACITY_DEF,
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  srs_pkg::rank_ctl_t                 ctl,
  input  logic [IDX_W-1:0]                   front,
  input  logic signed [srs_pkg::SCORE_W-1:0] entry_score,
  input  logic [IDX_W-1:0]                   entry_tag,
  output logic [CNT_W-1:0]                   rank
);

  logic signed [srs_pkg::SCORE_W-1:0] ref_score_r;
  logic [IDX_W-1:0]                   ref_pos_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic [IDX_W-1:0]                   entry_pos;
  logic                               beats;

  // list position relative to the current front, wraps cleanly
  assign entry_pos = entry_tag - front;

  // ties go to the entry further back in the list
  assign beats = (entry_score > ref_score_r) ||
                 ((entry_score == ref_score_r) && (entry_pos > ref_pos_r));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ref_score_r <= entry_score;
      ref_pos_r   <= entry_pos;
      cnt_r       <= '0;
    end else if (ctl.acc && beats) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rank = cnt_r;

endmodule

>>> src/score_ranking_sorter_unit.sv
// Ranking table of up to CAPACITY entries (score plus 32-byte name). An add puts
// the entry at the front of the list, or returns status full; a clear empties the
// table; each gives one result with last set. A read ranks the table by
// descending score, ties going to the entry nearer the back of the list, stores
// that order and returns one result per entry with its rank, last on the final
// one (status empty on an empty table). Entries stay in fixed slots; only their
// list tags change. An add, clear or unused code passes from S_IDLE to S_SEND,
// where its result waits for the output handshake. A read ranks the entries
// one reference at a time through S_LOAD, S_REF, S_CMP and S_DONE, paced by the
// single score comparator fed from one read port of the entry store, then
// gives each result via S_OUTP, S_OUTS, S_OUTL and S_SEND. No item is taken
// until the last result is accepted. No clearing pass is needed after reset.
module score_ranking_sorter_unit #(
  parameter int CAPACITY = srs_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srs_pkg::out_item_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_REF  = 9'b000000100,
    S_CMP  = 9'b000001000,
    S_DONE = 9'b000010000,
    S_OUTP = 9'b000100000,
    S_OUTS = 9'b001000000,
    S_OUTL = 9'b010000000,
    S_SEND = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   r_r, r_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic               out_valid_r, out_valid_nxt;
  srs_pkg::out_item_t out_r, out_nxt;

  // slot of each rank, filled during ranking and walked on readout
  logic [IDX_W-1:0]   perm_mem [CAPACITY];
  logic [IDX_W-1:0]   perm_q_r;
  logic               perm_we;

  srs_pkg::store_ctl_t                st_ctl;
  srs_pkg::rank_ctl_t                 rk_ctl;
  logic [IDX_W-1:0]                   rd_addr;
  logic [IDX_W-1:0]                   tag_addr;
  logic [IDX_W-1:0]                   wr_tag;
  srs_pkg::name_blk_t                 wr_name;
  logic signed [srs_pkg::SCORE_W-1:0] rd_score;
  srs_pkg::name_blk_t                 rd_name;
  logic [IDX_W-1:0]                   rd_tag;
  logic [CNT_W-1:0]                   rank_cnt;
  logic [CNT_W:0]                     r_plus;

  assign wr_name[0] = in_data.name_word0;
  assign wr_name[1] = in_data.name_word1;
  assign wr_name[2] = in_data.name_word2;
  assign wr_name[3] = {{(srs_pkg::NAME_W - srs_pkg::NAME_KEEP_W){1'b0}},
                       in_data.name_word3[srs_pkg::NAME_KEEP_W-1:0]};

  assign r_plus = {1'b0, r_r} + 1'b1;

  // tag writes: new entry on an add, rank position on readout
  assign tag_addr = (state_r == S_OUTS) ? perm_q_r : count_r[IDX_W-1:0];
  assign wr_tag   = (state_r == S_OUTS) ? front_r + r_r[IDX_W-1:0] : front_r - 1'b1;

  assign rk_ctl.acc  = cmp_v_r;
  assign rk_ctl.load = (state_r == S_REF);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    r_nxt           = r_r;
    cmp_v_nxt       = 1'b0;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    perm_we         = 1'b0;
    st_ctl.entry_we = 1'b0;
    st_ctl.tag_we   = 1'b0;
    rd_addr         = i_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          out_nxt        = '0;
          out_nxt.status = srs_pkg::ST_OK;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_SEND;
          unique case (in_data.action)
            srs_pkg::ACT_ADD: begin
              if (count_r == CAP_CNT) begin
                out_nxt.status = srs_pkg::ST_FULL;
              end else begin
                st_ctl.entry_we = 1'b1;
                st_ctl.tag_we   = 1'b1;
                front_nxt       = front_r - 1'b1;
                count_nxt       = count_r + 1'b1;
              end
            end
            srs_pkg::ACT_READ: begin
              if (count_r == '0) begin
                out_nxt.status = srs_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                i_nxt         = '0;
                state_nxt     = S_LOAD;
              end
            end
            srs_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            srs_pkg::ACT_NONE: begin
              count_nxt = count_r;
            end
          endcase
        end
      end
      S_LOAD: begin
        rd_addr   = i_r[IDX_W-1:0];
        state_nxt = S_REF;
      end
      S_REF: begin
        j_nxt     = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // stream every entry past the reference, one read per cycle
        if (j_r < count_r) begin
          rd_addr   = j_r[IDX_W-1:0];
          j_nxt     = j_r + 1'b1;
          cmp_v_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        perm_we = 1'b1;
        if (i_r + 1'b1 == count_r) begin
          r_nxt     = '0;
          state_nxt = S_OUTP;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_OUTP: begin
        state_nxt = S_OUTS;
      end
      S_OUTS: begin
        rd_addr       = perm_q_r;
        st_ctl.tag_we = 1'b1;
        state_nxt     = S_OUTL;
      end
      S_OUTL: begin
        out_nxt.status      = srs_pkg::ST_OK;
        out_nxt.rank        = srs_pkg::RANK_W'(r_plus);
        out_nxt.entry_score = rd_score;
        out_nxt.entry_name0 = rd_name[0];
        out_nxt.entry_name1 = rd_name[1];
        out_nxt.entry_name2 = rd_name[2];
        out_nxt.entry_name3 = rd_name[3];
        out_nxt.last        = (r_plus == {1'b0, count_r});
        out_valid_nxt       = 1'b1;
        state_nxt           = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            r_nxt     = r_r + 1'b1;
            state_nxt = S_OUTP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      front_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      r_r         <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      r_r         <= r_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[rank_cnt[IDX_W-1:0]] <= i_r[IDX_W-1:0];
    end
    perm_q_r <= perm_mem[r_r[IDX_W-1:0]];
  end

  srs_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk      (clk),
    .ctl      (st_ctl),
    .wr_addr  (count_r[IDX_W-1:0]),
    .wr_score (in_data.score),
    .wr_name  (wr_name),
    .tag_addr (tag_addr),
    .wr_tag   (wr_tag),
    .rd_addr  (rd_addr),
    .rd_score (rd_score),
    .rd_name  (rd_name),
    .rd_tag   (rd_tag)
  );

  srs_rank #(
    .CAPACITY (CAPACITY)
  ) u_rank (
    .clk         (clk),
    .ctl         (rk_ctl),
    .front       (front_r),
    .entry_score (rd_score),
    .entry_tag   (rd_tag),
    .rank        (rank_cnt)
  );

endmodule

>>> bench/tb_top.sv
module tb_top;

  localparam int CAP          = srs_pkg::CAPACITY_DEF;
  localparam int SCORE_W      = srs_pkg::SCORE_W;
  localparam int NAME_W       = srs_pkg::NAME_W;
  localparam int NAME_KEEP_W  = srs_pkg::NAME_KEEP_W;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SWAP_FROM    = 96;
  localparam int NO_IDLE_FROM = 108;
  localparam int LAST_ITEM    = 120;
  localparam logic [NAME_W-1:0] NAME_KEEP_MASK =
    {{(NAME_W-NAME_KEEP_W){1'b0}}, {NAME_KEEP_W{1'b1}}};

  typedef struct {
    srs_pkg::in_item_t  item;
    bit                 typed;
    srs_pkg::out_item_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  srs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  srs_pkg::out_item_t out_data;

  // mirror of the ranking table, front of the list at index 0
  logic signed [SCORE_W-1:0] tbl_score [CAP];
  srs_pkg::name_blk_t        tbl_name [CAP];
  int                        tbl_count = 0;

  srs_pkg::out_item_t new_results[$];
  srs_pkg::out_item_t ranking_due_q[$];
  dir_row_t           dir_rows[$];

  int mismatches  = 0;
  int sent        = 0;
  int tx_idle_pct = 14;
  int rx_idle_pct = 74;
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_cnt    = 0;
  int cycles      = 0;

  score_ranking_sorter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic srs_pkg::in_item_t make_item(srs_pkg::action_t act,
                                                  logic [SCORE_W-1:0] sc,
                                                  logic [NAME_W-1:0] n0,
                                                  logic [NAME_W-1:0] n1,
                                                  logic [NAME_W-1:0] n2,
                                                  logic [NAME_W-1:0] n3);
    srs_pkg::in_item_t it;
    it.action     = act;
    it.score      = sc;
    it.name_word0 = n0;
    it.name_word1 = n1;
    it.name_word2 = n2;
    it.name_word3 = n3;
    return it;
  endfunction

  function automatic srs_pkg::out_item_t ack(srs_pkg::status_t st);
    srs_pkg::out_item_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic logic [NAME_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // a mix of wide, tie-prone and extreme scores
  function automatic logic [SCORE_W-1:0] rand_score();
    logic [SCORE_W-1:0] s;
    case ($urandom_range(3))
      0: s = $urandom_range(4);
      1: begin
        case ($urandom_range(3))
          0: s = 32'h7FFF_FFFF;
          1: s = 32'h8000_0000;
          2: s = 32'hFFFF_FFFF;
          default: s = '0;
        endcase
      end
      default: s = $urandom;
    endcase
    return s;
  endfunction

  function automatic srs_pkg::in_item_t rand_add();
    return make_item(srs_pkg::ACT_ADD, rand_score(), rand_word(), rand_word(),
                     rand_word(), rand_word());
  endfunction

  function automatic srs_pkg::in_item_t plain_item(srs_pkg::action_t act);
    return make_item(act, $urandom, rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  function automatic void add_row(srs_pkg::in_item_t it, bit typed,
                                  srs_pkg::out_item_t r);
    dir_row_t d;
    d.item  = it;
    d.typed = typed;
    d.res   = r;
    dir_rows.push_back(d);
  endfunction

  // works out the results of one item and updates the table mirror;
  // ties rank the entry nearer the back of the list first
  function automatic void rank_table(srs_pkg::in_item_t it);
    int                        ord [CAP];
    logic signed [SCORE_W-1:0] s_new [CAP];
    srs_pkg::name_blk_t        n_new [CAP];
    srs_pkg::out_item_t        r;
    int                        k, j, t;
    new_results.delete();
    r      = '0;
    r.last = 1'b1;
    case (it.action)
      srs_pkg::ACT_READ: begin
        if (tbl_count == 0) begin
          r.status = srs_pkg::ST_EMPTY;
          new_results.push_back(r);
        end else begin
          for (k = 0; k < tbl_count; k++) ord[k] = k;
          for (k = 1; k < tbl_count; k++) begin
            t = ord[k];
            j = k;
            while (j > 0 && (tbl_score[t] > tbl_score[ord[j-1]] ||
                   (tbl_score[t] == tbl_score[ord[j-1]] && t > ord[j-1]))) begin
              ord[j] = ord[j-1];
              j--;
            end
            ord[j] = t;
          end
          for (k = 0; k < tbl_count; k++) begin
            s_new[k] = tbl_score[ord[k]];
            n_new[k] = tbl_name[ord[k]];
          end
          for (k = 0; k < tbl_count; k++) begin
            tbl_score[k]  = s_new[k];
            tbl_name[k]   = n_new[k];
            r.status      = srs_pkg::ST_OK;
            r.rank        = srs_pkg::RANK_W'(k + 1);
            r.entry_score = s_new[k];
            r.entry_name0 = n_new[k][0];
            r.entry_name1 = n_new[k][1];
            r.entry_name2 = n_new[k][2];
            r.entry_name3 = n_new[k][3];
            r.last        = (k == tbl_count - 1);
            new_results.push_back(r);
          end
        end
      end
      srs_pkg::ACT_ADD: begin
        if (tbl_count >= CAP) begin
          r.status = srs_pkg::ST_FULL;
        end else begin
          for (k = tbl_count; k > 0; k--) begin
            tbl_score[k] = tbl_score[k-1];
            tbl_name[k]  = tbl_name[k-1];
          end
          tbl_score[0] = it.score;
          tbl_name[0]  = {it.name_word3 & NAME_KEEP_MASK, it.name_word2, it.name_word1,
                          it.name_word0};
          tbl_count++;
        end
        new_results.push_back(r);
      end
      srs_pkg::ACT_CLEAR: begin
        tbl_count = 0;
        new_results.push_back(r);
      end
      default: new_results.push_back(r);
    endcase
  endfunction

  task automatic send_item(srs_pkg::in_item_t it, bit typed, srs_pkg::out_item_t fixed);
    if (sent >= NO_IDLE_FROM) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (sent >= SWAP_FROM) begin
      tx_idle_pct = 74;
      rx_idle_pct = 14;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rank_table(it);
    if (typed) begin
      ranking_due_q.push_back(fixed);
    end else begin
      foreach (new_results[i]) ranking_due_q.push_back(new_results[i]);
    end
    sent++;
  endtask

  function automatic void match_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (holds_taken != holds_asked) begin
      out_ready   <= 1'b0;
      hold_cnt    <= HOLD_CYCLES;
      holds_taken <= holds_taken + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    srs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (ranking_due_q.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        mismatches++;
      end else begin
        want = ranking_due_q.pop_front();
        match_field("status", want.status, out_data.status);
        match_field("rank", want.rank, out_data.rank);
        match_field("entry_score", want.entry_score, out_data.entry_score);
        match_field("entry_name0", want.entry_name0, out_data.entry_name0);
        match_field("entry_name1", want.entry_name1, out_data.entry_name1);
        match_field("entry_name2", want.entry_name2, out_data.entry_name2);
        match_field("entry_name3", want.entry_name3, out_data.entry_name3);
        match_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int adds;
    srs_pkg::out_item_t none_res;
    none_res = '0;

    add_row(make_item(srs_pkg::ACT_READ, '0, '0, '0, '0, '0), 1'b1,
            ack(srs_pkg::ST_EMPTY));
    add_row(make_item(srs_pkg::ACT_NONE, '0, '0, '0, '0, '0), 1'b1, ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'h7FFF_FFFF, '1, '1, '1, '1), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'h8000_0000, '0, '0, '0, '0), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'h0, {16{4'hA}}, {16{4'h5}}, {16{4'hA}},
                      {16{4'h5}}), 1'b1, ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'hFFFF_FFFF, {16{4'h5}}, {16{4'hA}},
                      {16{4'h5}}, {16{4'hA}}), 1'b1, ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'h0, 64'h1, 64'h2, 64'h3,
                      64'hFF00_0000_0000_0004), 1'b1, ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_NONE, 32'h1234_5678, '1, '1, '1, '1), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_READ, '0, '0, '0, '0, '0), 1'b0, none_res);
    // sorted table read again: the tied pair swaps back
    add_row(make_item(srs_pkg::ACT_READ, '1, '1, '1, '1, '1), 1'b0, none_res);
    add_row(make_item(srs_pkg::ACT_ADD, 32'd7, 64'h11, 64'h12, 64'h13, 64'h14), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'd7, 64'h21, 64'h22, 64'h23, 64'h24), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_ADD, 32'd7, 64'h31, 64'h32, 64'h33, 64'h34), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_READ, '0, '0, '0, '0, '0), 1'b0, none_res);
    add_row(make_item(srs_pkg::ACT_CLEAR, '0, '0, '0, '0, '0), 1'b1, ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_READ, '0, '0, '0, '0, '0), 1'b1,
            ack(srs_pkg::ST_EMPTY));
    add_row(make_item(srs_pkg::ACT_ADD, 32'd1, 64'hCAFE, 64'h0, 64'hBEEF, '1), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_READ, '0, '0, '0, '0, '0), 1'b0, none_res);
    add_row(make_item(srs_pkg::ACT_CLEAR, 32'hDEAD_BEEF, '1, '1, '1, '1), 1'b1,
            ack(srs_pkg::ST_OK));
    add_row(make_item(srs_pkg::ACT_CLEAR, '0, '0, '0, '0, '0), 1'b1, ack(srs_pkg::ST_OK));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // fill to capacity behind a long receiver hold-off, then overflow
    holds_asked++;
    send_item(plain_item(srs_pkg::ACT_CLEAR), 1'b0, none_res);
    for (k = 0; k < CAP + 2; k++) send_item(rand_add(), 1'b0, none_res);
    send_item(plain_item(srs_pkg::ACT_READ), 1'b0, none_res);
    send_item(plain_item(srs_pkg::ACT_READ), 1'b0, none_res);

    while (sent < LAST_ITEM) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) < 3) send_item(plain_item(srs_pkg::ACT_CLEAR), 1'b0, none_res);
        adds = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(6, 1);
        repeat (adds) send_item(rand_add(), 1'b0, none_res);
        send_item(plain_item(srs_pkg::ACT_READ), 1'b0, none_res);
      end else begin
        case ($urandom_range(3))
          0: send_item(plain_item(srs_pkg::ACT_NONE), 1'b0, none_res);
          1: send_item(plain_item(srs_pkg::ACT_CLEAR), 1'b0, none_res);
          2: send_item(plain_item(srs_pkg::ACT_READ), 1'b0, none_res);
          default: send_item(rand_add(), 1'b0, none_res);
        endcase
      end
    end
    in_valid <= 1'b0;

    while (ranking_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/srs_pkg.sv
src/srs_store.sv
src/srs_rank.sv
src/score_ranking_sorter_unit.sv
bench/tb_top.sv
